>>> hw/rtl/fes_pkg.sv
// fes_pkg: types and constants shared by the fire effect heat buffer
// no dependencies

package fes_pkg;

  localparam int unsigned ROW_CELLS   = 64;
  localparam int unsigned ROW_COUNT   = 32;
  localparam int unsigned MAX_HEAT    = 36;
  localparam int unsigned CELL_TOTAL  = ROW_CELLS * ROW_COUNT;

  localparam int unsigned IDX_W  = 11;
  localparam int unsigned HEAT_W = 6;
  localparam int unsigned DROP_W = 2;
  localparam int unsigned ADDR_W = $clog2(CELL_TOTAL);
  localparam int unsigned COL_W  = $clog2(ROW_CELLS);
  localparam int unsigned DST_W  =
    ($clog2(CELL_TOTAL + 4) > IDX_W + 1) ? $clog2(CELL_TOTAL + 4) : IDX_W + 1;

  localparam logic [ADDR_W-1:0] BOTTOM_BASE = ADDR_W'(CELL_TOTAL - ROW_CELLS);
  localparam logic [HEAT_W-1:0] HEAT_FULL   = HEAT_W'(MAX_HEAT);

  typedef enum logic [1:0] {
    FN_SPREAD = 2'd0,
    FN_IGNITE = 2'd1,
    FN_DOUSE  = 2'd2,
    FN_READ   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FILL
  } state_e;

  typedef struct packed {
    func_e             func;
    logic [IDX_W-1:0]  cell_index;
    logic [DROP_W-1:0] random_drop;
  } req_t;

  typedef struct packed {
    logic [HEAT_W-1:0] cell_value;
    logic              wrote;
    logic [IDX_W-1:0]  write_index;
  } rsp_t;

endpackage

>>> hw/rtl/fire_effect_spread.sv
// fire_effect_spread: heat buffer of a fire effect in one synchronous memory
// depends on fes_pkg
//
// usage: a request is taken at a clock edge with start high and busy low.
// req_i carries func, cell_index and random_drop. every request gives
// exactly one response on rsp_o, shown for one cycle with done_o high.
// the receiver cannot stall; the response register is simply overwritten
// by the next one.
// spread and read make one memory read; spread then does the dependent
// write, and both give the response. the heat memory is single-port.
// ignite and douse sweep the bottom row, one cell a cycle, over all
// ROW_CELLS (64) cells, then give the response.
// after reset the block runs a clearing pass over all CELL_TOTAL (2048)
// cells, writing MAX_HEAT into the bottom row and 0 elsewhere; busy stays
// high until the pass is through.

module fire_effect_spread
  import fes_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output rsp_t rsp_o,
  output logic done_o
);

  logic [HEAT_W-1:0] mem_q [CELL_TOTAL];
  logic [HEAT_W-1:0] rdata_q;

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic [COL_W-1:0]  col_q, col_d;
  func_e             func_q, func_d;
  logic              ok_q, ok_d;
  logic [ADDR_W-1:0] tgt_q, tgt_d;
  logic [DROP_W-1:0] drop_q, drop_d;
  logic [HEAT_W-1:0] fill_q, fill_d;
  rsp_t              rsp_q, rsp_d;
  logic              done_q, done_d;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [HEAT_W-1:0] mem_wdata;

  logic [DST_W-1:0]  dst_p3;
  logic              src_ok;
  logic              dst_ok;
  logic [HEAT_W-1:0] drop_ext;
  logic [HEAT_W-1:0] new_heat;

  // target plus ROW_CELLS plus three, so that it never goes negative
  assign dst_p3 = DST_W'(req_i.cell_index) + DST_W'(4) - DST_W'(req_i.random_drop);
  assign src_ok = DST_W'(req_i.cell_index) < DST_W'(CELL_TOTAL);
  assign dst_ok = (dst_p3 >= DST_W'(ROW_CELLS + 3)) && (dst_p3 <= DST_W'(CELL_TOTAL + 3));

  assign drop_ext = HEAT_W'(drop_q);
  assign new_heat = (rdata_q > drop_ext) ? (rdata_q - drop_ext) : '0;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      col_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      col_q     <= col_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    ok_q   <= ok_d;
    tgt_q  <= tgt_d;
    drop_q <= drop_d;
    fill_q <= fill_d;
    rsp_q  <= rsp_d;
  end

  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    col_d     = col_q;
    func_d    = func_q;
    ok_d      = ok_q;
    tgt_d     = tgt_q;
    drop_d    = drop_q;
    fill_d    = fill_q;
    rsp_d     = rsp_q;
    done_d    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = req_i.cell_index[ADDR_W-1:0];
    mem_wdata = '0;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_q;
        mem_wdata = (clr_cnt_q >= BOTTOM_BASE) ? HEAT_FULL : '0;
        clr_cnt_d = clr_cnt_q + ADDR_W'(1);
        if (clr_cnt_q == ADDR_W'(CELL_TOTAL - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          func_d = req_i.func;
          drop_d = req_i.random_drop;
          tgt_d  = ADDR_W'(dst_p3 - DST_W'(ROW_CELLS + 3));
          col_d  = '0;
          fill_d = (req_i.func == FN_IGNITE) ? HEAT_FULL : '0;
          case (req_i.func)
            FN_SPREAD: begin
              ok_d    = src_ok && dst_ok;
              state_d = ST_READ;
            end
            FN_READ: begin
              ok_d    = src_ok;
              state_d = ST_READ;
            end
            default: begin
              ok_d    = 1'b0;
              state_d = ST_FILL;
            end
          endcase
        end
      end
      ST_READ: begin
        rsp_d   = '0;
        done_d  = 1'b1;
        state_d = ST_IDLE;
        if (func_q == FN_SPREAD) begin
          if (ok_q) begin
            mem_we            = 1'b1;
            mem_addr          = tgt_q;
            mem_wdata         = new_heat;
            rsp_d.cell_value  = new_heat;
            rsp_d.wrote       = 1'b1;
            rsp_d.write_index = IDX_W'(tgt_q);
          end
        end else if (ok_q) begin
          rsp_d.cell_value = rdata_q;
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_addr  = BOTTOM_BASE + ADDR_W'(col_q);
        mem_wdata = fill_q;
        col_d     = col_q + COL_W'(1);
        if (col_q == COL_W'(ROW_CELLS - 1)) begin
          rsp_d   = '0;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy   = (state_q != ST_IDLE);
  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule
